// ===== hdl/sfla_pkg.sv =====
package sfla_pkg;

    // default sizes
    localparam int BLOCK_BYTES_DEF   = 1024 * 1024;
    localparam int SMALL_CLASSES_DEF = 32;
    localparam int SMALL_DEPTH_DEF   = 16;
    localparam int BIG_ENTRIES_DEF   = 64;
    localparam int LIVE_ENTRIES_DEF  = 256;
    localparam int ADDR_BITS_DEF     = 32;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LIMIT   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_ZERO    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 1;
    localparam logic [0:0] CFG_MAX_POOL  = 1'd0;
    localparam logic [0:0] CFG_POOL_BASE = 1'd1;

    // datapath operations
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE        = 5'd0;
    localparam op_t OP_LOAD        = 5'd1;
    localparam op_t OP_RD_SMALL    = 5'd2;
    localparam op_t OP_RD_FRONT    = 5'd3;
    localparam op_t OP_RD_BACK     = 5'd4;
    localparam op_t OP_TAKE_SMALL  = 5'd5;
    localparam op_t OP_TAKE_FRONT  = 5'd6;
    localparam op_t OP_TAKE_BACK   = 5'd7;
    localparam op_t OP_NEWBLK      = 5'd8;
    localparam op_t OP_LK_START    = 5'd9;
    localparam op_t OP_LK_STEP     = 5'd10;
    localparam op_t OP_RES_ZERO    = 5'd11;
    localparam op_t OP_RES_LIMIT   = 5'd12;
    localparam op_t OP_RES_UNKNOWN = 5'd13;
    localparam op_t OP_RES_FULL    = 5'd14;
    localparam op_t OP_COMMIT      = 5'd15;
    localparam op_t OP_INS_RD      = 5'd16;
    localparam op_t OP_INS_WR      = 5'd17;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic zero;
        logic over;
        logic small_hit;
        logic big_ne;
        logic fits;
        logic pool_over;
        logic lk_done;
        logic miss;
        logic full;
        logic put_big;
        logic ins_j0;
        logic ins_stop;
    } stat_t;

endpackage

// ===== hdl/sfla_chan_if.sv =====
interface sfla_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] req_size;
    logic [31:0] free_addr;
    modport source (output valid, req_type, req_size, free_addr, input ready);
    modport sink (input valid, req_type, req_size, free_addr, output ready);
endinterface

interface sfla_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] grant_addr;
    logic [23:0] granted_bytes;
    logic [31:0] used_bytes;
    modport source (output valid, status, grant_addr, granted_bytes, used_bytes, input ready);
    modport sink (input valid, status, grant_addr, granted_bytes, used_bytes, output ready);
endinterface

interface sfla_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfla_pkg::CFG_IDX_W-1:0] reg_index;
    logic [31:0]                    wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== hdl/sfla_dp.sv =====
module sfla_dp #(
    parameter int BLOCK_BYTES   = sfla_pkg::BLOCK_BYTES_DEF,
    parameter int SMALL_CLASSES = sfla_pkg::SMALL_CLASSES_DEF,
    parameter int SMALL_DEPTH   = sfla_pkg::SMALL_DEPTH_DEF,
    parameter int BIG_ENTRIES   = sfla_pkg::BIG_ENTRIES_DEF,
    parameter int LIVE_ENTRIES  = sfla_pkg::LIVE_ENTRIES_DEF,
    parameter int ADDR_BITS     = sfla_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sfla_pkg::cmd_t                 cmd,
    output sfla_pkg::stat_t                stat,
    input  logic                           in_type,
    input  logic [23:0]                    in_size,
    input  logic [31:0]                    in_addr,
    input  logic                           cfg_we,
    input  logic [sfla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    output logic [2:0]                     status,
    output logic [31:0]                    grant_addr,
    output logic [23:0]                    granted_bytes,
    output logic [31:0]                    used_bytes
);

    localparam int CLW = (SMALL_CLASSES > 1) ? $clog2(SMALL_CLASSES) : 1;
    localparam int HDW = (SMALL_DEPTH > 1) ? $clog2(SMALL_DEPTH) : 1;
    localparam int CNW = $clog2(SMALL_DEPTH + 1);
    localparam int PW  = CNW + 1;
    localparam int STN = SMALL_CLASSES * SMALL_DEPTH;
    localparam int STW = (STN > 1) ? $clog2(STN) : 1;
    localparam int BIW = $clog2(BIG_ENTRIES);
    localparam int BCW = $clog2(BIG_ENTRIES + 1);
    localparam int LIW = $clog2(LIVE_ENTRIES);
    localparam int EW  = ADDR_BITS + 24;
    localparam int SMALL_MAX = SMALL_CLASSES * 8;

    localparam logic [2:0] P_SMALL = 3'd0;
    localparam logic [2:0] P_FRONT = 3'd1;
    localparam logic [2:0] P_BACK  = 3'd2;
    localparam logic [2:0] P_NEW   = 3'd3;
    localparam logic [2:0] P_FREE  = 3'd4;

    sfla_pkg::op_t op;

    // configuration and totals
    logic [31:0] max_pool_reg;
    logic [31:0] pool_base_reg;
    logic [32:0] pool_granted_reg;
    logic [31:0] used_reg;

    // current request
    logic [23:0]          sz_reg;
    logic                 over_reg;
    logic                 zero_reg;
    logic                 small_reg;
    logic [CLW-1:0]       cls_reg;
    logic [2:0]           path_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [23:0]          put_size_reg;
    logic [24:0]          msz_reg;
    logic                 pool_over_reg;

    // small class fifos
    logic [CNW-1:0]       cnt_reg [SMALL_CLASSES];
    logic [HDW-1:0]       head_reg [SMALL_CLASSES];
    logic [ADDR_BITS-1:0] st_mem [STN];
    logic [ADDR_BITS-1:0] st_rdata_reg;

    // big free list, circular and sorted by size
    logic [EW-1:0]  b_mem [BIG_ENTRIES];
    logic [EW-1:0]  b_rdata_reg;
    logic [BIW-1:0] bhead_reg;
    logic [BCW-1:0] bcount_reg;
    logic [BCW-1:0] ins_j_reg;

    // live table
    logic [EW-1:0]           l_mem [LIVE_ENTRIES];
    logic [EW-1:0]           l_rdata_reg;
    logic [LIVE_ENTRIES-1:0] lv_reg;
    logic [LIW-1:0]          lk_idx_reg;
    logic [LIW-1:0]          cmp_idx_reg;
    logic                    cmp_vld_reg;
    logic                    found_reg;
    logic [LIW-1:0]          hit_slot_reg;
    logic                    have_free_reg;
    logic [LIW-1:0]          free_slot_reg;

    // result
    logic [2:0]  res_status_reg;
    logic [31:0] res_addr_reg;
    logic [23:0] res_bytes_reg;

    // combinational
    logic [24:0]           sz_full;
    logic [ADDR_BITS+31:0] fa_ext;
    logic                  put_small;
    logic [CLW-1:0]        put_cls;
    logic [CLW-1:0]        cnt_idx;
    logic [CNW-1:0]        cnt_cur;
    logic [HDW-1:0]        head_cur;
    logic [HDW-1:0]        head_inc;
    logic [PW-1:0]         put_sum;
    logic [PW-1:0]         put_pos;
    logic [STW:0]          st_base;
    logic [STW:0]          st_rd_full;
    logic [STW:0]          st_wr_full;
    logic [BIW-1:0]        b_front;
    logic [BIW-1:0]        b_back;
    logic [BIW-1:0]        b_insm1;
    logic [BIW-1:0]        b_ins;
    logic [BIW-1:0]        bhead_inc;
    logic [23:0]           b_rd_size;
    logic [ADDR_BITS-1:0]  b_rd_addr;
    logic [ADDR_BITS-1:0]  l_rd_addr;
    logic                  hit_now;
    logic                  lk_reset;
    logic [LIW-1:0]        slot;
    logic                  room;
    logic                  spare;
    logic [24:0]           msz_next;
    logic [33:0]           pool_sum;
    logic [ADDR_BITS+33:0] new_addr;
    logic [ADDR_BITS-1:0]  put_addr;
    logic [ADDR_BITS+31:0] res_ext;
    logic [EW-1:0]         new_ent;

    function automatic logic is_small(input logic [23:0] s);
        return (s != 24'd0) && (s[2:0] == 3'd0) && (s <= 24'(SMALL_MAX));
    endfunction

    function automatic logic [CLW-1:0] cls_idx(input logic [23:0] s);
        logic [23:0] q;
        q = (s >> 3) - 24'd1;
        return q[CLW-1:0];
    endfunction

    // logical list position to memory row
    function automatic logic [BIW-1:0] phys(input logic [BIW-1:0] h, input logic [BCW-1:0] j);
        logic [BCW:0] s;
        s = (BCW + 1)'(h) + (BCW + 1)'(j);
        if (s >= (BCW + 1)'(BIG_ENTRIES))
            s = s - (BCW + 1)'(BIG_ENTRIES);
        return s[BIW-1:0];
    endfunction

    assign op = cmd.op;

    // request decode
    assign sz_full = (25'(in_size) + 25'd7) & ~25'd7;
    assign fa_ext  = (ADDR_BITS + 32)'(in_addr);

    // small class access
    assign put_small = is_small(put_size_reg);
    assign put_cls   = cls_idx(put_size_reg);
    assign cnt_idx   = (path_reg == P_SMALL) ? cls_reg : put_cls;
    assign cnt_cur   = cnt_reg[cnt_idx];
    assign head_cur  = head_reg[cnt_idx];
    assign head_inc  = (head_cur == HDW'(SMALL_DEPTH - 1)) ? '0 : head_cur + HDW'(1);
    assign put_sum   = PW'(head_cur) + PW'(cnt_cur);
    assign put_pos   = (put_sum >= PW'(SMALL_DEPTH)) ? put_sum - PW'(SMALL_DEPTH) : put_sum;
    assign st_base   = (STW + 1)'(cnt_idx) * (STW + 1)'(SMALL_DEPTH);
    assign st_rd_full = st_base + (STW + 1)'(head_cur);
    assign st_wr_full = st_base + (STW + 1)'(put_pos[HDW-1:0]);

    // big list addressing
    assign b_front   = phys(bhead_reg, '0);
    assign b_back    = phys(bhead_reg, bcount_reg - BCW'(1));
    assign b_insm1   = phys(bhead_reg, ins_j_reg - BCW'(1));
    assign b_ins     = phys(bhead_reg, ins_j_reg);
    assign bhead_inc = (bhead_reg == BIW'(BIG_ENTRIES - 1)) ? '0 : bhead_reg + BIW'(1);
    assign b_rd_size = b_rdata_reg[23:0];
    assign b_rd_addr = b_rdata_reg[EW-1:24];
    assign new_ent   = {addr_reg, put_size_reg};

    // live table walk
    assign l_rd_addr = l_rdata_reg[EW-1:24];
    assign hit_now   = cmp_vld_reg && lv_reg[cmp_idx_reg] && (l_rd_addr == addr_reg);
    assign lk_reset  = (op == sfla_pkg::OP_LK_START) || (op == sfla_pkg::OP_TAKE_SMALL) ||
                       (op == sfla_pkg::OP_TAKE_FRONT) || (op == sfla_pkg::OP_TAKE_BACK);
    assign slot      = found_reg ? hit_slot_reg : free_slot_reg;

    // room for the remainder or freed buffer
    assign spare = (path_reg == P_FRONT) || (path_reg == P_BACK);
    assign room  = (put_size_reg == 24'd0) ||
                   (put_small ? (cnt_cur < CNW'(SMALL_DEPTH))
                              : (spare || (bcount_reg < BCW'(BIG_ENTRIES))));

    // new block carve
    assign msz_next = (25'(sz_reg) > 25'(BLOCK_BYTES)) ? 25'(sz_reg) : 25'(BLOCK_BYTES);
    assign pool_sum = 34'(msz_next) + 34'(pool_granted_reg);
    assign new_addr = (ADDR_BITS + 34)'(pool_base_reg) + (ADDR_BITS + 34)'(pool_granted_reg);
    assign put_addr = (path_reg == P_FREE) ? addr_reg : addr_reg + ADDR_BITS'(sz_reg);
    assign res_ext  = (ADDR_BITS + 32)'(addr_reg);

    // status to controller
    assign stat.is_free   = (path_reg == P_FREE);
    assign stat.zero      = zero_reg;
    assign stat.over      = over_reg;
    assign stat.small_hit = small_reg && (cnt_cur != '0);
    assign stat.big_ne    = (bcount_reg != '0);
    assign stat.fits      = (sz_reg <= b_rd_size);
    assign stat.pool_over = pool_over_reg;
    assign stat.lk_done   = cmp_vld_reg && (hit_now || (cmp_idx_reg == LIW'(LIVE_ENTRIES - 1)));
    assign stat.miss      = (path_reg == P_FREE) && !found_reg;
    assign stat.full      = !room || (!found_reg && !have_free_reg);
    assign stat.put_big   = (put_size_reg != 24'd0) && !put_small;
    assign stat.ins_j0    = (ins_j_reg == '0);
    assign stat.ins_stop  = (b_rd_size < put_size_reg);

    // control state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pool_reg     <= '1;
            pool_base_reg    <= '0;
            pool_granted_reg <= '0;
            used_reg         <= '0;
            bhead_reg        <= '0;
            bcount_reg       <= '0;
            lv_reg           <= '0;
            for (int c = 0; c < SMALL_CLASSES; c++)
            begin
                cnt_reg[c]  <= '0;
                head_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sfla_pkg::CFG_MAX_POOL:  max_pool_reg  <= cfg_wdata;
                    sfla_pkg::CFG_POOL_BASE: pool_base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (op)
                sfla_pkg::OP_COMMIT:
                begin
                    case (path_reg)
                        P_SMALL:
                        begin
                            cnt_reg[cnt_idx]  <= cnt_cur - CNW'(1);
                            head_reg[cnt_idx] <= head_inc;
                        end
                        P_FRONT:
                        begin
                            bhead_reg  <= bhead_inc;
                            bcount_reg <= bcount_reg - BCW'(1);
                        end
                        P_BACK:  bcount_reg <= bcount_reg - BCW'(1);
                        P_NEW:   pool_granted_reg <= pool_granted_reg + 33'(msz_reg);
                        default: ;
                    endcase
                    if (path_reg != P_SMALL && put_small)
                        cnt_reg[cnt_idx] <= cnt_cur + CNW'(1);
                    if (path_reg == P_FREE)
                    begin
                        lv_reg[slot] <= 1'b0;
                        used_reg     <= used_reg - 32'(sz_reg);
                    end
                    else
                    begin
                        lv_reg[slot] <= 1'b1;
                        used_reg     <= used_reg + 32'(sz_reg);
                    end
                end
                sfla_pkg::OP_INS_RD:
                    if (ins_j_reg == '0)
                        bcount_reg <= bcount_reg + BCW'(1);
                sfla_pkg::OP_INS_WR:
                    if (b_rd_size < put_size_reg)
                        bcount_reg <= bcount_reg + BCW'(1);
                default: ;
            endcase
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        case (op)
            sfla_pkg::OP_LOAD:
            begin
                sz_reg    <= sz_full[23:0];
                over_reg  <= sz_full[24];
                zero_reg  <= (in_size == 24'd0);
                small_reg <= is_small(sz_full[23:0]);
                cls_reg   <= cls_idx(sz_full[23:0]);
                addr_reg  <= fa_ext[ADDR_BITS-1:0];
                path_reg  <= in_type ? P_FREE : P_SMALL;
            end
            sfla_pkg::OP_TAKE_SMALL:
            begin
                addr_reg     <= st_rdata_reg;
                put_size_reg <= 24'd0;
            end
            sfla_pkg::OP_TAKE_FRONT:
            begin
                addr_reg     <= b_rd_addr;
                put_size_reg <= b_rd_size - sz_reg;
                path_reg     <= P_FRONT;
            end
            sfla_pkg::OP_TAKE_BACK:
            begin
                addr_reg     <= b_rd_addr;
                put_size_reg <= b_rd_size - sz_reg;
                path_reg     <= P_BACK;
            end
            sfla_pkg::OP_NEWBLK:
            begin
                msz_reg       <= msz_next;
                pool_over_reg <= pool_sum > 34'(max_pool_reg);
                addr_reg      <= new_addr[ADDR_BITS-1:0];
                put_size_reg  <= 24'(msz_next - 25'(sz_reg));
                path_reg      <= P_NEW;
            end
            sfla_pkg::OP_LK_STEP:
                if (hit_now && path_reg == P_FREE)
                begin
                    sz_reg       <= l_rdata_reg[23:0];
                    put_size_reg <= l_rdata_reg[23:0];
                end
            sfla_pkg::OP_COMMIT: addr_reg <= put_addr;
            default: ;
        endcase
    end

    // live table walk registers
    always_ff @(posedge clk)
    begin
        if (lk_reset)
        begin
            lk_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else if (op == sfla_pkg::OP_LK_STEP)
        begin
            cmp_idx_reg <= lk_idx_reg;
            cmp_vld_reg <= 1'b1;
            lk_idx_reg  <= (lk_idx_reg == LIW'(LIVE_ENTRIES - 1)) ? '0 : lk_idx_reg + LIW'(1);
            if (hit_now)
            begin
                found_reg    <= 1'b1;
                hit_slot_reg <= cmp_idx_reg;
            end
            if (cmp_vld_reg && !lv_reg[cmp_idx_reg] && !have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_slot_reg <= cmp_idx_reg;
            end
        end
        if (op == sfla_pkg::OP_COMMIT)
        begin
            if (path_reg == P_FRONT || path_reg == P_BACK)
                ins_j_reg <= bcount_reg - BCW'(1);
            else
                ins_j_reg <= bcount_reg;
        end
        else if (op == sfla_pkg::OP_INS_WR && !(b_rd_size < put_size_reg))
            ins_j_reg <= ins_j_reg - BCW'(1);
    end

    // result registers
    always_ff @(posedge clk)
    begin
        case (op)
            sfla_pkg::OP_RES_ZERO, sfla_pkg::OP_RES_LIMIT,
            sfla_pkg::OP_RES_UNKNOWN, sfla_pkg::OP_RES_FULL:
            begin
                res_addr_reg  <= '0;
                res_bytes_reg <= '0;
                case (op)
                    sfla_pkg::OP_RES_ZERO:    res_status_reg <= sfla_pkg::ST_ZERO;
                    sfla_pkg::OP_RES_LIMIT:   res_status_reg <= sfla_pkg::ST_LIMIT;
                    sfla_pkg::OP_RES_UNKNOWN: res_status_reg <= sfla_pkg::ST_UNKNOWN;
                    default:                  res_status_reg <= sfla_pkg::ST_FULL;
                endcase
            end
            sfla_pkg::OP_COMMIT:
            begin
                res_status_reg <= sfla_pkg::ST_OK;
                res_addr_reg   <= res_ext[31:0];
                res_bytes_reg  <= sz_reg;
            end
            default: ;
        endcase
    end

    // small fifo store
    always_ff @(posedge clk)
    begin
        if (op == sfla_pkg::OP_COMMIT && path_reg != P_SMALL && put_small)
            st_mem[st_wr_full[STW-1:0]] <= put_addr;
        if (op == sfla_pkg::OP_RD_SMALL)
            st_rdata_reg <= st_mem[st_rd_full[STW-1:0]];
    end

    // big list memory
    always_ff @(posedge clk)
    begin
        if (op == sfla_pkg::OP_INS_RD && ins_j_reg == '0)
            b_mem[b_front] <= new_ent;
        else if (op == sfla_pkg::OP_INS_WR)
        begin
            if (b_rd_size < put_size_reg)
                b_mem[b_ins] <= new_ent;
            else
                b_mem[b_ins] <= b_rdata_reg;
        end
        case (op)
            sfla_pkg::OP_RD_FRONT: b_rdata_reg <= b_mem[b_front];
            sfla_pkg::OP_RD_BACK:  b_rdata_reg <= b_mem[b_back];
            sfla_pkg::OP_INS_RD:   b_rdata_reg <= b_mem[b_insm1];
            default: ;
        endcase
    end

    // live table memory
    always_ff @(posedge clk)
    begin
        if (op == sfla_pkg::OP_COMMIT && path_reg != P_FREE)
            l_mem[slot] <= {addr_reg, sz_reg};
        if (op == sfla_pkg::OP_LK_STEP)
            l_rdata_reg <= l_mem[lk_idx_reg];
    end

    assign status        = res_status_reg;
    assign grant_addr    = res_addr_reg;
    assign granted_bytes = res_bytes_reg;
    assign used_bytes    = used_reg;

endmodule

// ===== hdl/sfla_ctrl.sv =====
module sfla_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  sfla_pkg::stat_t stat,
    output sfla_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SMALLD = 4'd2;
    localparam logic [3:0] S_FRONTD = 4'd3;
    localparam logic [3:0] S_BACKD  = 4'd4;
    localparam logic [3:0] S_CHKNEW = 4'd5;
    localparam logic [3:0] S_LOOKUP = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_INS_RD = 4'd8;
    localparam logic [3:0] S_INS_WR = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sfla_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = sfla_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            S_DECODE:
                if (stat.is_free)
                begin
                    cmd.op     = sfla_pkg::OP_LK_START;
                    state_next = S_LOOKUP;
                end
                else if (stat.zero)
                begin
                    cmd.op     = sfla_pkg::OP_RES_ZERO;
                    state_next = S_OUT;
                end
                else if (stat.over)
                begin
                    cmd.op     = sfla_pkg::OP_RES_LIMIT;
                    state_next = S_OUT;
                end
                else if (stat.small_hit)
                begin
                    cmd.op     = sfla_pkg::OP_RD_SMALL;
                    state_next = S_SMALLD;
                end
                else if (stat.big_ne)
                begin
                    cmd.op     = sfla_pkg::OP_RD_FRONT;
                    state_next = S_FRONTD;
                end
                else
                begin
                    cmd.op     = sfla_pkg::OP_NEWBLK;
                    state_next = S_CHKNEW;
                end
            S_SMALLD:
            begin
                cmd.op     = sfla_pkg::OP_TAKE_SMALL;
                state_next = S_LOOKUP;
            end
            S_FRONTD:
                if (stat.fits)
                begin
                    cmd.op     = sfla_pkg::OP_TAKE_FRONT;
                    state_next = S_LOOKUP;
                end
                else
                begin
                    cmd.op     = sfla_pkg::OP_RD_BACK;
                    state_next = S_BACKD;
                end
            S_BACKD:
                if (stat.fits)
                begin
                    cmd.op     = sfla_pkg::OP_TAKE_BACK;
                    state_next = S_LOOKUP;
                end
                else
                begin
                    cmd.op     = sfla_pkg::OP_NEWBLK;
                    state_next = S_CHKNEW;
                end
            S_CHKNEW:
                if (stat.pool_over)
                begin
                    cmd.op     = sfla_pkg::OP_RES_LIMIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = sfla_pkg::OP_LK_START;
                    state_next = S_LOOKUP;
                end
            S_LOOKUP:
            begin
                cmd.op = sfla_pkg::OP_LK_STEP;
                if (stat.lk_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
                if (stat.miss)
                begin
                    cmd.op     = sfla_pkg::OP_RES_UNKNOWN;
                    state_next = S_OUT;
                end
                else if (stat.full)
                begin
                    cmd.op     = sfla_pkg::OP_RES_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = sfla_pkg::OP_COMMIT;
                    state_next = stat.put_big ? S_INS_RD : S_OUT;
                end
            S_INS_RD:
            begin
                cmd.op     = sfla_pkg::OP_INS_RD;
                state_next = stat.ins_j0 ? S_OUT : S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.op     = sfla_pkg::OP_INS_WR;
                state_next = stat.ins_stop ? S_OUT : S_INS_RD;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/segregated_free_list_allocator.sv =====
// Segregated free-list allocator. One request at a time: alloc or free in,
// one result item out (status, address, aligned bytes, bytes in use). A
// request searches up to LIVE_ENTRIES live table entries, one per cycle
// through the live table's single read port, with a registered read; a sorted
// big-list insert reads and then writes each big-list entry it moves through
// the big list memory port. Configuration writes are always taken; no clearing
// pass is needed after reset.
module segregated_free_list_allocator #(
    parameter int BLOCK_BYTES   = sfla_pkg::BLOCK_BYTES_DEF,
    parameter int SMALL_CLASSES = sfla_pkg::SMALL_CLASSES_DEF,
    parameter int SMALL_DEPTH   = sfla_pkg::SMALL_DEPTH_DEF,
    parameter int BIG_ENTRIES   = sfla_pkg::BIG_ENTRIES_DEF,
    parameter int LIVE_ENTRIES  = sfla_pkg::LIVE_ENTRIES_DEF,
    parameter int ADDR_BITS     = sfla_pkg::ADDR_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    sfla_req_if.sink   req,
    sfla_rsp_if.source rsp,
    sfla_cfg_if.sink   cfg
);

    sfla_pkg::cmd_t  cmd;
    sfla_pkg::stat_t stat;

    // register writes never stall
    assign cfg.ready = 1'b1;

    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfla_dp #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .SMALL_CLASSES (SMALL_CLASSES),
        .SMALL_DEPTH   (SMALL_DEPTH),
        .BIG_ENTRIES   (BIG_ENTRIES),
        .LIVE_ENTRIES  (LIVE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_type       (req.req_type),
        .in_size       (req.req_size),
        .in_addr       (req.free_addr),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.reg_index),
        .cfg_wdata     (cfg.wdata),
        .status        (rsp.status),
        .grant_addr    (rsp.grant_addr),
        .granted_bytes (rsp.granted_bytes),
        .used_bytes    (rsp.used_bytes)
    );

endmodule

// ===== tb/sv/segregated_free_list_allocator_tb.sv =====
`timescale 1ns / 1ps

module segregated_free_list_allocator_tb;

    localparam int BLOCK_B  = sfla_pkg::BLOCK_BYTES_DEF;
    localparam int NCLS     = sfla_pkg::SMALL_CLASSES_DEF;
    localparam int SDEPTH   = sfla_pkg::SMALL_DEPTH_DEF;
    localparam int NBIG     = sfla_pkg::BIG_ENTRIES_DEF;
    localparam int NLIVE    = sfla_pkg::LIVE_ENTRIES_DEF;
    localparam int SMALL_MX = NCLS * 8;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [23:0] bytes;
        logic [31:0] used;
    } grant_t;

    // Allocator shadow: predicts one grant per request and checks the block's answers
    class alloc_shadow;
        bit [31:0]  max_pool;
        bit [31:0]  base;
        bit [31:0]  fifo_mem [NCLS][SDEPTH];
        int         fifo_cnt [NCLS];
        int         fifo_hd  [NCLS];
        bit [31:0]  big_addr [$];
        int         big_size [$];
        bit         lv_valid [NLIVE];
        bit [31:0]  lv_addr  [NLIVE];
        int         lv_size  [NLIVE];
        bit [31:0]  used;
        longint     granted;
        grant_t     pending [$];
        int         errors;

        function new();
            max_pool = 32'hFFFF_FFFF;
            base = 0;
            used = 0;
            granted = 0;
            errors = 0;
            foreach (fifo_cnt[i])
            begin
                fifo_cnt[i] = 0;
                fifo_hd[i] = 0;
            end
            foreach (lv_valid[i])
                lv_valid[i] = 0;
        endfunction

        function int cls_of(int sz);
            if (sz == 0 || sz > SMALL_MX || (sz & 7) != 0)
                return -1;
            return sz / 8 - 1;
        endfunction

        function bit room(int sz, int spare);
            int c;
            c = cls_of(sz);
            if (sz == 0)
                return 1;
            if (c >= 0)
                return fifo_cnt[c] < SDEPTH;
            return big_size.size() < NBIG + spare;
        endfunction

        function void put_free(bit [31:0] a, int sz);
            int c;
            int i;
            c = cls_of(sz);
            if (sz == 0)
                return;
            if (c >= 0)
            begin
                if (fifo_cnt[c] >= SDEPTH)
                    return;
                fifo_mem[c][(fifo_hd[c] + fifo_cnt[c]) % SDEPTH] = a;
                fifo_cnt[c]++;
                return;
            end
            if (big_size.size() >= NBIG)
                return;
            for (i = 0; i < big_size.size(); i++)
                if (sz <= big_size[i])
                    break;
            big_size.insert(i, sz);
            big_addr.insert(i, a);
        endfunction

        function int find_live(bit [31:0] a);
            for (int i = 0; i < NLIVE; i++)
                if (lv_valid[i] && lv_addr[i] == a)
                    return i;
            return -1;
        endfunction

        function void note_request(bit typ, bit [23:0] req, bit [31:0] fa);
            grant_t g;
            int     sz;
            int     c;
            int     path;
            int     slot;
            int     rem;
            int     spare;
            longint msz;
            bit [31:0] a;
            g = '0;
            g.status = sfla_pkg::ST_OK;
            rem = 0;
            spare = 0;
            msz = 0;
            a = 0;
            if (!typ)
            begin
                sz = (int'(req) + 7) & ~7;
                c = cls_of(sz);
                if (req == 0)
                    g.status = sfla_pkg::ST_ZERO;
                else if (sz > 24'hFFFFFF)
                    g.status = sfla_pkg::ST_LIMIT;
                else
                begin
                    if (c >= 0 && fifo_cnt[c] > 0)
                    begin
                        path = 0;
                        a = fifo_mem[c][fifo_hd[c]];
                    end
                    else if (big_size.size() > 0 && sz <= big_size[0])
                    begin
                        path = 1;
                        a = big_addr[0];
                        rem = big_size[0] - sz;
                        spare = 1;
                    end
                    else if (big_size.size() > 0 && sz <= big_size[$])
                    begin
                        path = 2;
                        a = big_addr[$];
                        rem = big_size[$] - sz;
                        spare = 1;
                    end
                    else
                    begin
                        path = 3;
                        msz = (sz > BLOCK_B) ? sz : BLOCK_B;
                        if (msz + granted > longint'(max_pool))
                            g.status = sfla_pkg::ST_LIMIT;
                        a = base + 32'(granted);
                        rem = int'(msz - sz);
                    end
                    if (g.status == sfla_pkg::ST_OK)
                    begin
                        slot = find_live(a);
                        if (slot < 0)
                            for (int i = 0; i < NLIVE; i++)
                                if (!lv_valid[i])
                                begin
                                    slot = i;
                                    break;
                                end
                        if (slot < 0 || !room(rem, spare))
                            g.status = sfla_pkg::ST_FULL;
                        else
                        begin
                            case (path)
                                0:
                                begin
                                    fifo_hd[c] = (fifo_hd[c] + 1) % SDEPTH;
                                    fifo_cnt[c]--;
                                end
                                1:
                                begin
                                    big_size.delete(0);
                                    big_addr.delete(0);
                                end
                                2:
                                begin
                                    big_size.delete(big_size.size() - 1);
                                    big_addr.delete(big_addr.size() - 1);
                                end
                                default: granted += msz;
                            endcase
                            lv_valid[slot] = 1;
                            lv_addr[slot] = a;
                            lv_size[slot] = sz;
                            put_free(a + 32'(sz), rem);
                            used += 32'(sz);
                            g.addr = a;
                            g.bytes = 24'(sz);
                        end
                    end
                end
            end
            else
            begin
                slot = find_live(fa);
                if (slot < 0)
                    g.status = sfla_pkg::ST_UNKNOWN;
                else if (!room(lv_size[slot], 0))
                    g.status = sfla_pkg::ST_FULL;
                else
                begin
                    sz = lv_size[slot];
                    lv_valid[slot] = 0;
                    put_free(fa, sz);
                    used -= 32'(sz);
                    g.addr = fa;
                    g.bytes = 24'(sz);
                end
            end
            g.used = used;
            pending = {pending, g};
        endfunction

        function void check_grant(grant_t got);
            grant_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.status !== exp.status)
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            if (got.addr !== exp.addr)
                $display("%0t: grant_addr expected %h actual %h", $time, exp.addr, got.addr);
            if (got.bytes !== exp.bytes)
                $display("%0t: granted_bytes expected %h actual %h", $time, exp.bytes,
                         got.bytes);
            if (got.used !== exp.used)
                $display("%0t: used_bytes expected %h actual %h", $time, exp.used, got.used);
            if (got !== exp)
                errors++;
        endfunction

        // pick a live address, or a random one if none
        function bit [31:0] some_live();
            int n;
            n = 0;
            for (int i = 0; i < NLIVE; i++)
                if (lv_valid[i])
                    n++;
            if (n == 0)
                return $urandom;
            n = $urandom_range(n - 1);
            for (int i = 0; i < NLIVE; i++)
                if (lv_valid[i])
                begin
                    if (n == 0)
                        return lv_addr[i];
                    n--;
                end
            return 0;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    sfla_req_if req ();
    sfla_rsp_if rsp ();
    sfla_cfg_if cfg ();

    alloc_shadow shadow;

    segregated_free_list_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always #5 clk = ~clk;

    // result side: random stall bursts, check on each accepted item
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready = 0;
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                shadow.check_grant({rsp.status, rsp.grant_addr, rsp.granted_bytes,
                                    rsp.used_bytes});
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 0;
            end
            else if (!calm && $urandom_range(9) == 0)
            begin
                stall = $urandom_range(17, 0);
                rsp.ready <= 0;
            end
            else
                rsp.ready <= 1;
        end
    end

    // valid stays high after the accepting edge until the next item or an idle gap
    task automatic send_req(bit typ, bit [23:0] sz, bit [31:0] fa);
        if (!calm && $urandom_range(7) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(18, 1)) @(posedge clk);
        end
        req.valid <= 1;
        req.req_type <= typ;
        req.req_size <= sz;
        req.free_addr <= fa;
        do
            @(posedge clk);
        while (!req.ready);
        shadow.note_request(typ, sz, fa);
    endtask

    task automatic write_reg(logic [sfla_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
        cfg.valid <= 1;
        cfg.reg_index <= idx;
        cfg.wdata <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 0;
        if (idx == sfla_pkg::CFG_MAX_POOL)
            shadow.max_pool = val;
        else
            shadow.base = val;
        @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (NLIVE + 2 * NBIG + 20) @(posedge clk);
    endtask

    // random size: mostly small classes, some medium, a few large
    function automatic bit [23:0] rand_size();
        int k;
        k = $urandom_range(99);
        if (k < 55)
            return 24'($urandom_range(SMALL_MX));
        if (k < 85)
            return 24'($urandom_range(4096, SMALL_MX + 1));
        if (k < 97)
            return 24'($urandom_range(BLOCK_B * 2, 4096));
        return 24'($urandom);
    endfunction

    task automatic random_phase(int n);
        bit [31:0] fa;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 45)
            begin
                fa = shadow.some_live();
                if ($urandom_range(9) == 0)
                    fa = $urandom;
                send_req(1, 24'($urandom), fa);
            end
            else
                send_req(0, rand_size(), $urandom);
        end
    endtask

    initial
    begin
        shadow = new();
        clk = 0;
        rst_n = 0;
        calm = 0;
        req.valid = 0;
        req.req_type = 0;
        req.req_size = 0;
        req.free_addr = 0;
        cfg.valid = 0;
        cfg.reg_index = sfla_pkg::CFG_MAX_POOL;
        cfg.wdata = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, the ok, zero, limit and unknown statuses, splits and reuse
        send_req(0, 0, 0);
        send_req(0, 24'hFFFFFF, 0);
        send_req(0, 24'hFFFFF9, 0);
        send_req(0, 1, 0);
        send_req(0, 24'(SMALL_MX), 0);
        send_req(0, 24'(SMALL_MX + 1), 0);
        send_req(1, 0, 0);
        send_req(1, 0, 32'hFFFF_FFFF);
        send_req(1, 0, 32'(BLOCK_B + 8));
        send_req(1, 24'hABCDEF, 32'(BLOCK_B + 8));
        send_req(0, 3, 0);
        send_req(0, 100, 0);
        send_req(0, 5000, 0);
        send_req(0, 24'(BLOCK_B + 1), 0);
        send_req(1, 0, 0);
        send_req(0, 8, 0);
        send_req(0, 24'h800000, 0);
        drain();

        write_reg(sfla_pkg::CFG_MAX_POOL, 0);
        write_reg(sfla_pkg::CFG_POOL_BASE, 32'hFFFF_FFF0);
        send_req(0, 20000, 0);
        send_req(0, 8, 0);
        drain();
        write_reg(sfla_pkg::CFG_MAX_POOL, 32'h0400_0000);
        send_req(0, 64, 0);
        send_req(0, 24'hFFFFF0, 0);
        random_phase(300);
        drain();

        write_reg(sfla_pkg::CFG_MAX_POOL, 32'hFFFF_FFFF);
        write_reg(sfla_pkg::CFG_POOL_BASE, $urandom);
        random_phase(500);
        drain();

        write_reg(sfla_pkg::CFG_MAX_POOL, 32'h00C0_0000);
        write_reg(sfla_pkg::CFG_POOL_BASE, 0);
        random_phase(300);
        drain();

        calm = 1;
        random_phase(280);
        drain();

        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("** segregated_free_list_allocator: PASSED **");
        else
            $display("** segregated_free_list_allocator: FAILED **");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("** segregated_free_list_allocator: FAILED **");
        $finish;
    end

endmodule
